[rtl/integer_to_radix_ascii_defines.svh]
// Assertion macros shared by the integer-to-ASCII checker
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define IRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define IRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ira_pkg.sv]
// Package: shared constants, types and helpers of the integer-to-ASCII converter
`default_nettype none

package ira_pkg;

  // default width of the converted integer
  localparam int VALUE_BITS_DEF = 32;

  // conversion kind codes on req_type
  localparam logic [1:0] REQ_DEC = 2'd0;
  localparam logic [1:0] REQ_HEX = 2'd1;
  localparam logic [1:0] REQ_BIN = 2'd2;

  // ASCII codes
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;
  localparam logic [7:0] CHAR_LC_B  = 8'h62;

  // digit layout of the shift register
  typedef enum logic [1:0] {
    MODE_DEC,
    MODE_HEX,
    MODE_BIN
  } mode_t;

  // sequencer -> digit unit
  typedef struct packed {
    logic  load;
    mode_t mode;
    logic  dabble;
    logic  shift;
  } du_cmd_t;

  // digit unit -> sequencer
  typedef struct packed {
    logic [3:0] digit;
    logic       last_digit;
    logic       conv_busy;
    mode_t      mode;
  } du_stat_t;

  // decimal digits needed for an unsigned number of the given width
  function automatic int dec_digits(input int bits);
    return (bits * 301) / 1000 + 1;
  endfunction

  // one digit value to its lower-case ASCII code
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d > 4'd9) begin
      return CHAR_LC_A + {4'd0, d} - 8'd10;
    end
    return CHAR_ZERO + {4'd0, d};
  endfunction

endpackage

`default_nettype wire

[rtl/ira_if.sv]
// Interfaces: number request channel and character result channel
`default_nettype none

interface ira_in_if #(
  parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
  modport mon    (input valid, input req_type, input value, input ready);
endinterface

interface ira_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
  modport mon    (input valid, input ascii_char, input last_char, input ready);
endinterface

`default_nettype wire

[rtl/integer_to_radix_ascii.sv]
// Top level: integer to ASCII text in decimal, hexadecimal or binary
//
// in_chan takes one transaction per number: req_type (0 decimal, 1 hex with
// "0x", 2 binary with "0b", 3 as decimal) and a signed value. out_chan then
// gives the text one character per transaction: '-' if negative, the prefix,
// then the digits most significant first; last_char marks the final one.
// After acceptance a decimal number goes through the double-dabble loop of
// the shared shift register; hex and binary skip it. Leading zero digits are
// then dropped at one per cycle (up to 9 decimal, 7 hex, 31 binary at 32
// bits), and the characters go out one at a time as the receiver takes them.
// The next number is accepted in the cycle after the last character enters
// the output register.
// in_chan.ready is high only while no number is being worked on.
// The output register holds a character until it is taken; a stalled
// receiver stops the sequencer at its next character without loss. Reset
// empties the output register and returns the sequencer to idle.
`default_nettype none

module integer_to_radix_ascii #(
  parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ira_in_if.sink   in_chan,
  ira_out_if.source out_chan
);
  import ira_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_PFX0,
    S_PFX1,
    S_SKIP,
    S_DIGIT
  } state_t;

  state_t                state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;
  logic [VALUE_BITS-1:0] in_val_u;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  mode_t                 req_mode;
  du_cmd_t               cmd;
  du_stat_t              stat;

  // request decode and magnitude
  assign in_val_u = in_chan.value;
  assign neg_in   = in_val_u[VALUE_BITS-1];
  assign mag_in   = neg_in ? (~in_val_u + 1'b1) : in_val_u;

  always_comb begin
    unique case (in_chan.req_type)
      REQ_HEX: req_mode = MODE_HEX;
      REQ_BIN: req_mode = MODE_BIN;
      default: req_mode = MODE_DEC;
    endcase
  end

  // shared conversion / digit shift unit
  ira_digit_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .mag   (mag_in),
    .stat  (stat)
  );

  assign out_free = !out_valid_r || out_chan.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cmd           = '0;
    cmd.mode      = req_mode;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd.load = 1'b1;
          neg_nxt  = neg_in;
          if (req_mode == MODE_DEC) begin
            state_nxt = S_CONV;
          end else begin
            state_nxt = neg_in ? S_SIGN : S_PFX0;
          end
        end
      end
      S_CONV: begin
        if (stat.conv_busy) begin
          cmd.dabble = 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_SKIP;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = (stat.mode == MODE_DEC) ? S_SKIP : S_PFX0;
        end
      end
      S_PFX0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = S_PFX1;
        end
      end
      S_PFX1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = (stat.mode == MODE_HEX) ? CHAR_LC_X : CHAR_LC_B;
          out_last_nxt  = 1'b0;
          state_nxt     = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (stat.digit == 4'd0 && !stat.last_digit) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(stat.digit);
          out_last_nxt  = stat.last_digit;
          cmd.shift     = 1'b1;
          if (stat.last_digit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.ascii_char = out_char_r;
  assign out_chan.last_char  = out_last_r;

endmodule

`default_nettype wire

[rtl/ira_digit_unit.sv]
// Digit unit: shared shift register for double-dabble conversion and digit output
`default_nettype none

module ira_digit_unit #(
  parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ira_pkg::du_cmd_t      cmd,
  input  wire logic [VALUE_BITS-1:0] mag,
  output ira_pkg::du_stat_t          stat
);
  import ira_pkg::*;

  localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DW         = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  logic [DW-1:0]         sh_r, sh_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      digs_r, digs_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [DW-1:0]         adj;
  logic [3:0]            nib;

  // next-value logic: load, one double-dabble step, or one digit shift
  always_comb begin
    sh_nxt   = sh_r;
    bin_nxt  = bin_r;
    cnt_nxt  = cnt_r;
    digs_nxt = digs_r;
    mode_nxt = mode_r;
    adj      = sh_r;
    nib      = '0;
    if (cmd.load) begin
      mode_nxt = cmd.mode;
      bin_nxt  = mag;
      unique case (cmd.mode)
        MODE_HEX: begin
          sh_nxt   = DW'(mag) << (DW - 4 * HEX_DIGITS);
          cnt_nxt  = '0;
          digs_nxt = CNT_W'(HEX_DIGITS);
        end
        MODE_BIN: begin
          sh_nxt   = DW'(mag) << (DW - VALUE_BITS);
          cnt_nxt  = '0;
          digs_nxt = CNT_W'(VALUE_BITS);
        end
        default: begin
          sh_nxt   = '0;
          cnt_nxt  = CNT_W'(VALUE_BITS);
          digs_nxt = CNT_W'(DEC_DIGITS);
        end
      endcase
    end else if (cmd.dabble) begin
      // add 3 to every BCD digit of 5 or more, then shift one binary bit in
      for (int i = 0; i < DEC_DIGITS; i++) begin
        nib = sh_r[4*i +: 4];
        adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
      {sh_nxt, bin_nxt} = {adj, bin_r} << 1;
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.shift) begin
      sh_nxt   = (mode_r == MODE_BIN) ? (sh_r << 1) : (sh_r << 4);
      digs_nxt = digs_r - 1'b1;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    sh_r   <= sh_nxt;
    bin_r  <= bin_nxt;
    digs_r <= digs_nxt;
    mode_r <= mode_nxt;
  end

  // status: leading digit sits at the top of the register
  assign stat.digit      = (mode_r == MODE_BIN) ? {3'd0, sh_r[DW-1]} : sh_r[DW-1 -: 4];
  assign stat.last_digit = (digs_r == CNT_W'(1));
  assign stat.conv_busy  = (cnt_r != '0);
  assign stat.mode       = mode_r;

endmodule

`default_nettype wire

[rtl/ira_checker.sv]
// Checker on the converter's ports, bound to the top level
`default_nettype none

`include "integer_to_radix_ascii_defines.svh"

module ira_checker (
  input wire logic  clk,
  input wire logic  rst_n,
  ira_in_if.sink    in_chan,
  ira_out_if.source out_chan
);

  // a stalled character stays offered
  `IRA_ASSERT_NEXT(a_out_hold, out_chan.valid && !out_chan.ready, out_chan.valid, "out valid dropped while stalled")

  // a stalled character does not change
  `IRA_ASSERT_NEXT(a_out_stable, out_chan.valid && !out_chan.ready, $stable(out_chan.ascii_char) && $stable(out_chan.last_char), "out payload changed while stalled")

  // a new number is never taken in the cycle after one was accepted
  `IRA_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready, "ready right after accept")

  // while a character before the end is pending, the number is not finished
  `IRA_ASSERT_NOW(a_no_accept_mid_text, out_chan.valid && !out_chan.last_char, !in_chan.ready, "ready before text complete")

endmodule

bind integer_to_radix_ascii ira_checker u_ira_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

`default_nettype wire

[tb/sv/integer_to_radix_ascii_tb.sv]
// Testbench: integer to radix ASCII converter, randomized with a text scoreboard
module integer_to_radix_ascii_tb;
  import ira_pkg::*;

  localparam int          WIDTH       = 32;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;   // unused kind, behaves as decimal
  localparam int          PHASE_ITEMS = 67;
  localparam int          DRAIN_CYCLES = 120;   // conversion + zero skip + characters
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } text_char_t;

  // Expected text of every accepted number, one character per entry
  class text_scoreboard;
    text_char_t text_q[$];
    int         errors;
    int         numbers;
    int         chars_seen;
    int         kind_count[4];

    function int pending();
      return text_q.size();
    endfunction

    // Render the text of one accepted number
    function void note_number(logic [1:0] kind, logic [WIDTH-1:0] value);
      logic [WIDTH-1:0] mag;
      logic [WIDTH-1:0] radix;
      logic [7:0]       prefix;
      logic [3:0]       digit_q[$];
      logic [7:0]       chars[$];
      text_char_t       tc;
      mag    = value[WIDTH-1] ? (~value + 1'b1) : value;
      prefix = 8'h00;
      case (kind)
        REQ_HEX: begin
          radix  = 16;
          prefix = CHAR_LC_X;
        end
        REQ_BIN: begin
          radix  = 2;
          prefix = CHAR_LC_B;
        end
        default: begin
          radix = 10;
        end
      endcase
      if (value[WIDTH-1]) chars.push_back(CHAR_MINUS);
      if (prefix != 8'h00) begin
        chars.push_back(CHAR_ZERO);
        chars.push_back(prefix);
      end
      // digits come out least significant first
      if (mag == 0) digit_q.push_front(4'd0);
      while (mag != 0) begin
        digit_q.push_front(4'(mag % radix));
        mag = mag / radix;
      end
      foreach (digit_q[i]) begin
        if (digit_q[i] > 4'd9) chars.push_back(CHAR_LC_A + 8'(digit_q[i]) - 8'd10);
        else chars.push_back(CHAR_ZERO + 8'(digit_q[i]));
      end
      foreach (chars[i]) begin
        tc.ascii_char = chars[i];
        tc.last_char  = (i == chars.size() - 1);
        text_q.push_back(tc);
      end
      numbers++;
      kind_count[kind]++;
    endfunction

    // Compare one received character with the oldest expected one
    function void check_char(logic [7:0] ascii_char, logic last_char);
      text_char_t exp_c;
      chars_seen++;
      if (text_q.size() == 0) begin
        $error("unexpected character 0x%02h (last_char %0b) with no number pending",
               ascii_char, last_char);
        errors++;
        return;
      end
      exp_c = text_q.pop_front();
      if (ascii_char !== exp_c.ascii_char) begin
        $error("ascii_char mismatch: expected 0x%02h actual 0x%02h",
               exp_c.ascii_char, ascii_char);
        errors++;
      end
      if (last_char !== exp_c.last_char) begin
        $error("last_char mismatch: expected %0b actual %0b", exp_c.last_char, last_char);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycles;

  text_scoreboard sb = new();

  ira_in_if #(.VALUE_BITS(WIDTH)) in_bus ();
  ira_out_if                      out_bus ();

  integer_to_radix_ascii #(.VALUE_BITS(WIDTH)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d characters still expected",
                 cycles, sb.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Character receiver: check accepted transactions, stall at random
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        sb.check_char(out_bus.ascii_char, out_bus.last_char);
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one number; returns once the transaction is accepted, valid left high
  task automatic send_number(input logic [1:0] kind, input logic [WIDTH-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= kind;
    in_bus.value    <= value;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_number(kind, value);
  endtask

  // Hold the sender off until all pending text has come out
  task automatic wait_text_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Random value biased toward varied digit counts and the extremes
  function automatic logic [WIDTH-1:0] pick_value();
    int               sel;
    logic [WIDTH-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $urandom;
    end else if (sel < 8) begin
      v = $urandom >> $urandom_range(0, WIDTH - 1);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (sel == 8) begin
      v = $urandom_range(0, 20) - 10;
    end else begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'hffff_ffff;
        default: v = 32'h0000_0000;
      endcase
    end
    return v;
  endfunction

  function automatic logic [1:0] pick_kind();
    if ($urandom_range(0, 15) == 0) return REQ_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  // Main sequence
  initial begin
    logic [WIDTH-1:0] corner[5];
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= REQ_DEC;
    in_bus.value    <= '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    corner[0] = 32'h0000_0000;
    corner[1] = 32'h0000_0001;
    corner[2] = 32'hffff_ffff;
    corner[3] = 32'h7fff_ffff;
    corner[4] = 32'h8000_0000;   // most negative, converts via unsigned magnitude
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, one, minus one and both extremes for every kind
    for (int k = 0; k < 4; k++)
      foreach (corner[i]) send_number(2'(k), corner[i]);
    // hex letters a-f, signed and unsigned; a ten-digit decimal and an eight-digit binary
    send_number(REQ_HEX, 32'h7fed_cba9);
    send_number(REQ_HEX, -32'h0abc_def0);
    send_number(REQ_DEC, 32'd1000000000);
    send_number(REQ_BIN, 32'h0000_00a5);
    wait_text_drained();

    // Random: three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_number(pick_kind(), pick_value());
        if (n == PHASE_ITEMS / 2) wait_text_drained();
      end
      wait_text_drained();
    end

    // Let any trailing activity settle
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected characters never arrived", sb.pending());
      sb.errors++;
    end

    $display("Converted %0d numbers to %0d characters: %0d decimal, %0d hex, %0d binary,",
             sb.numbers, sb.chars_seen, sb.kind_count[REQ_DEC], sb.kind_count[REQ_HEX],
             sb.kind_count[REQ_BIN]);
    $display("%0d with the unused kind, under three stall profiles; %0d mismatches.",
             sb.kind_count[REQ_UNUSED], sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
